@@ design/waypoint_track_interpolator_assert.svh @@
// Assertion macros for the waypoint track interpolator.
// Included by the RTL files that check their own control logic.
`ifndef WAYPOINT_TRACK_INTERPOLATOR_ASSERT_SVH
`define WAYPOINT_TRACK_INTERPOLATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WTI_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WTI_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/wti_pkg.sv @@
// Shared types and constants of the waypoint track interpolator.
// No dependencies; every other file but the assertion header imports it.
package wti_pkg;

  localparam int MAX_TARGETS   = 8;
  localparam int MAX_WAYPOINTS = 64;
  localparam int TGT_W         = $clog2(MAX_TARGETS);
  localparam int WP_W          = $clog2(MAX_WAYPOINTS);
  localparam int ADDR_W        = TGT_W + WP_W;
  localparam int TABLE_DEPTH   = MAX_TARGETS * MAX_WAYPOINTS;
  localparam int COORD_W       = 32;
  localparam int TICK_W        = 16;
  localparam int GAIN_W        = 16;
  localparam int TCNT_W        = 4;
  localparam int WCNT_W        = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TCNT_W-1:0] TCNT_RST = TCNT_W'(1);
  localparam logic [WCNT_W-1:0] WCNT_RST = WCNT_W'(1);
  localparam logic [TICK_W-1:0] TICK_RST = TICK_W'(1);
  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(256);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_STEP  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_COUNT   = 2'd0,
    CFG_WAYPOINT_COUNT = 2'd1,
    CFG_SEGMENT_TICKS  = 2'd2,
    CFG_VELOCITY_GAIN  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_STEP_RD,
    BK_STEP_MUL,
    BK_STEP_DIV,
    BK_STEP_WR,
    BK_STEP_END,
    BK_QRY_MUL,
    BK_QRY_OUT
  } back_state_t;

  typedef struct packed {
    opcode_t                    op;
    logic [TGT_W-1:0]           target_index;
    logic [WP_W-1:0]            waypoint_index;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
  } cmd_t;

endpackage

@@ design/wti_if.sv @@
// Channel interfaces: command input, query result and register writes.
// Depends on wti_pkg.
interface wti_in_if;
  import wti_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 opcode;
  logic [TGT_W-1:0]           target_index;
  logic [WP_W-1:0]            waypoint_index;
  logic signed [COORD_W-1:0]  coord_x;
  logic signed [COORD_W-1:0]  coord_y;
  modport source (output valid, opcode, target_index, waypoint_index, coord_x, coord_y,
                  input ready);
  modport sink   (input valid, opcode, target_index, waypoint_index, coord_x, coord_y,
                  output ready);
endinterface

interface wti_out_if;
  import wti_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_y;
  logic signed [COORD_W-1:0]  vel_x;
  logic signed [COORD_W-1:0]  vel_y;
  modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface wti_cfg_if;
  import wti_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   reg_index;
  logic [CFG_DATA_W-1:0]  wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ design/wti_fifo.sv @@
// Short command queue between the front and back parts.
// Depends on wti_pkg.
module wti_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  wti_pkg::cmd_t  push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output wti_pkg::cmd_t  pop_data
);
  import wti_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ design/wti_front.sv @@
// Front part: accept commands, classify them, drop those with no effect.
// Depends on wti_pkg and wti_if.
module wti_front (
  wti_in_if.sink         in_ch,
  output logic           push_valid,
  input  logic           push_ready,
  output wti_pkg::cmd_t  push_data
);
  import wti_pkg::*;

  opcode_t op;
  logic    load_ok;
  logic    keep;

  assign op = opcode_t'(in_ch.opcode);

  // A load to a slot beyond the table is dropped here.
  assign load_ok = ({1'b0, in_ch.target_index} < (TGT_W+1)'(MAX_TARGETS)) &&
                   ({1'b0, in_ch.waypoint_index} < (WP_W+1)'(MAX_WAYPOINTS));

  always_comb begin
    case (op)
      OP_LOAD:  keep = load_ok;
      OP_STEP:  keep = 1'b1;
      OP_QUERY: keep = 1'b1;
      default:  keep = 1'b0;
    endcase
  end

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid && keep;

  assign push_data.op             = op;
  assign push_data.target_index   = in_ch.target_index;
  assign push_data.waypoint_index = in_ch.waypoint_index;
  assign push_data.coord_x        = in_ch.coord_x;
  assign push_data.coord_y        = in_ch.coord_y;

endmodule

@@ design/wti_back.sv @@
// Back part: waypoint tables, target positions, step sequencer, query unit.
// Depends on wti_pkg, wti_if and the assertion macro header.
`include "waypoint_track_interpolator_assert.svh"
module wti_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  wti_pkg::cmd_t  pop_data,
  wti_cfg_if.sink        cfg_ch,
  wti_out_if.source      out_ch
);
  import wti_pkg::*;

  // Configuration
  logic [TCNT_W-1:0] tcnt_r;
  logic [WCNT_W-1:0] wcnt_r;
  logic [TICK_W-1:0] sticks_r;
  logic [GAIN_W-1:0] gain_r;
  logic [TCNT_W-1:0] tc_eff;
  logic [WCNT_W-1:0] wc_eff;
  logic [TICK_W-1:0] st_eff;

  // Track state
  logic [TICK_W-1:0]         phase_r;
  logic [WP_W-1:0]           seg_r;
  logic [1:0]                steps_r;
  logic signed [COORD_W-1:0] cur_x_r  [MAX_TARGETS];
  logic signed [COORD_W-1:0] cur_y_r  [MAX_TARGETS];
  logic signed [COORD_W-1:0] prev_x_r [MAX_TARGETS];
  logic signed [COORD_W-1:0] prev_y_r [MAX_TARGETS];

  // Waypoint memories
  logic [COORD_W-1:0] wpx_mem [TABLE_DEPTH];
  logic [COORD_W-1:0] wpy_mem [TABLE_DEPTH];
  logic [COORD_W-1:0] rda_x_r, rdb_x_r, rda_y_r, rdb_y_r;

  // Step work registers
  back_state_t        state_r, state_nxt;
  logic [TGT_W-1:0]   tgt_r;
  logic [TGT_W-1:0]   tgt_last_r;
  logic [TICK_W-1:0]  ph_w_r;
  logic [TICK_W-1:0]  st_w_r;
  logic [WCNT_W-1:0]  wc_w_r;
  logic [WP_W-1:0]    seg_w_r;
  logic [WP_W-1:0]    nxt_w_r;
  logic [COORD_W-1:0] base_x_r, base_y_r;
  logic               neg_x_r, neg_y_r;
  logic [TICK_W-1:0]  rem_x_r, rem_y_r;
  logic [COORD_W-1:0] dvd_x_r, dvd_y_r;
  logic [4:0]         div_cnt_r;

  // Query registers
  logic [TGT_W-1:0]          qtgt_r;
  logic                      qok_r;
  logic signed [COORD_W-1:0] qpos_x_r, qpos_y_r;
  logic signed [49:0]        vprod_x_r, vprod_y_r;

  // Result register
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r;

  // Control outputs
  logic mem_rd_en;
  logic load_en;
  logic step_start;
  logic query_start;
  logic result_load;

  // Start-of-step normalization
  logic [TICK_W-1:0] ph_norm;
  logic [WP_W-1:0]   seg_norm;
  logic [WCNT_W-1:0] seg_inc;
  logic [WP_W-1:0]   nxt_norm;

  // Datapath nets
  logic [ADDR_W-1:0]         addr_a, addr_b, addr_ld;
  logic signed [COORD_W:0]   diff_x, diff_y;
  logic [COORD_W-1:0]        mag_x, mag_y;
  logic [47:0]               prod_x, prod_y;
  logic [TICK_W:0]           trial_x, trial_y;
  logic                      qbit_x, qbit_y;
  logic [COORD_W-1:0]        quo_x, quo_y;
  logic signed [COORD_W:0]   vdiff_x, vdiff_y;
  logic signed [49:0]        vmul_x, vmul_y;
  logic signed [COORD_W-1:0] vel_x_c, vel_y_c;
  logic [TICK_W:0]           phase_inc;

  function automatic logic [COORD_W-1:0] vel_scale(input logic signed [49:0] p);
    logic signed [49:0] adj;
    logic signed [41:0] sh;
    begin
      adj = p + (p[49] ? 50'sd255 : 50'sd0);
      sh  = 42'(adj >>> 8);
      if ((sh[41:31] == '0) || (sh[41:31] == '1)) begin
        vel_scale = sh[31:0];
      end else begin
        vel_scale = sh[41] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
    end
  endfunction

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    if (tcnt_r == '0) begin
      tc_eff = TCNT_W'(1);
    end else if (tcnt_r > TCNT_W'(MAX_TARGETS)) begin
      tc_eff = TCNT_W'(MAX_TARGETS);
    end else begin
      tc_eff = tcnt_r;
    end
    if (wcnt_r == '0) begin
      wc_eff = WCNT_W'(1);
    end else if (wcnt_r > WCNT_W'(MAX_WAYPOINTS)) begin
      wc_eff = WCNT_W'(MAX_WAYPOINTS);
    end else begin
      wc_eff = wcnt_r;
    end
    st_eff = (sticks_r == '0) ? TICK_W'(1) : sticks_r;
  end

  // Stale counters fall back to zero before the step uses them.
  assign ph_norm  = (phase_r >= st_eff) ? '0 : phase_r;
  assign seg_norm = ({1'b0, seg_r} >= wc_eff) ? '0 : seg_r;
  assign seg_inc  = {1'b0, seg_norm} + 1'b1;
  assign nxt_norm = (seg_inc >= wc_eff) ? '0 : seg_inc[WP_W-1:0];

  assign addr_a  = {tgt_r, seg_w_r};
  assign addr_b  = {tgt_r, nxt_w_r};
  assign addr_ld = {pop_data.target_index, pop_data.waypoint_index};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (pop_valid) begin
          if (pop_data.op == OP_STEP) begin
            state_nxt = BK_STEP_RD;
          end else if (pop_data.op == OP_QUERY) begin
            state_nxt = BK_QRY_MUL;
          end
        end
      end
      BK_STEP_RD:  state_nxt = BK_STEP_MUL;
      BK_STEP_MUL: state_nxt = BK_STEP_DIV;
      BK_STEP_DIV: begin
        if (div_cnt_r == '0) begin
          state_nxt = BK_STEP_WR;
        end
      end
      BK_STEP_WR:  state_nxt = (tgt_r == tgt_last_r) ? BK_STEP_END : BK_STEP_RD;
      BK_STEP_END: state_nxt = BK_IDLE;
      BK_QRY_MUL:  state_nxt = BK_QRY_OUT;
      BK_QRY_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default:     state_nxt = BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop_ready   = 1'b0;
    mem_rd_en   = 1'b0;
    load_en     = 1'b0;
    step_start  = 1'b0;
    query_start = 1'b0;
    result_load = 1'b0;
    case (state_r)
      BK_IDLE: begin
        pop_ready   = 1'b1;
        load_en     = pop_valid && (pop_data.op == OP_LOAD);
        step_start  = pop_valid && (pop_data.op == OP_STEP);
        query_start = pop_valid && (pop_data.op == OP_QUERY);
      end
      BK_STEP_RD: mem_rd_en = 1'b1;
      BK_QRY_OUT: result_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // Interpolation datapath: |b - a| * phase, then restoring divide.
  assign diff_x = $signed({rdb_x_r[COORD_W-1], rdb_x_r}) - $signed({rda_x_r[COORD_W-1], rda_x_r});
  assign diff_y = $signed({rdb_y_r[COORD_W-1], rdb_y_r}) - $signed({rda_y_r[COORD_W-1], rda_y_r});
  assign mag_x  = diff_x[COORD_W] ? COORD_W'(-diff_x) : diff_x[COORD_W-1:0];
  assign mag_y  = diff_y[COORD_W] ? COORD_W'(-diff_y) : diff_y[COORD_W-1:0];
  assign prod_x = mag_x * ph_w_r;
  assign prod_y = mag_y * ph_w_r;

  assign trial_x = {rem_x_r, dvd_x_r[COORD_W-1]};
  assign trial_y = {rem_y_r, dvd_y_r[COORD_W-1]};
  assign qbit_x  = (trial_x >= {1'b0, st_w_r});
  assign qbit_y  = (trial_y >= {1'b0, st_w_r});
  assign quo_x   = neg_x_r ? -dvd_x_r : dvd_x_r;
  assign quo_y   = neg_y_r ? -dvd_y_r : dvd_y_r;

  assign phase_inc = {1'b0, ph_w_r} + 1'b1;

  // Velocity datapath
  assign vdiff_x = $signed({cur_x_r[qtgt_r][COORD_W-1], cur_x_r[qtgt_r]}) -
                   $signed({prev_x_r[qtgt_r][COORD_W-1], prev_x_r[qtgt_r]});
  assign vdiff_y = $signed({cur_y_r[qtgt_r][COORD_W-1], cur_y_r[qtgt_r]}) -
                   $signed({prev_y_r[qtgt_r][COORD_W-1], prev_y_r[qtgt_r]});
  assign vmul_x  = vdiff_x * $signed({1'b0, gain_r});
  assign vmul_y  = vdiff_y * $signed({1'b0, gain_r});
  assign vel_x_c = (qok_r && (steps_r == 2'd2)) ? $signed(vel_scale(vprod_x_r)) : '0;
  assign vel_y_c = (qok_r && (steps_r == 2'd2)) ? $signed(vel_scale(vprod_y_r)) : '0;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      tcnt_r      <= TCNT_RST;
      wcnt_r      <= WCNT_RST;
      sticks_r    <= TICK_RST;
      gain_r      <= GAIN_RST;
      phase_r     <= '0;
      seg_r       <= '0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_TARGETS; i++) begin
        cur_x_r[i]  <= '0;
        cur_y_r[i]  <= '0;
        prev_x_r[i] <= '0;
        prev_y_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        case (cfg_reg_t'(cfg_ch.reg_index))
          CFG_TARGET_COUNT:   tcnt_r   <= cfg_ch.wdata[TCNT_W-1:0];
          CFG_WAYPOINT_COUNT: wcnt_r   <= cfg_ch.wdata[WCNT_W-1:0];
          CFG_SEGMENT_TICKS:  sticks_r <= cfg_ch.wdata[TICK_W-1:0];
          CFG_VELOCITY_GAIN:  gain_r   <= cfg_ch.wdata[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (step_start) begin
        for (int i = 0; i < MAX_TARGETS; i++) begin
          prev_x_r[i] <= cur_x_r[i];
          prev_y_r[i] <= cur_y_r[i];
        end
      end
      if (state_r == BK_STEP_WR) begin
        cur_x_r[tgt_r] <= $signed(base_x_r + quo_x);
        cur_y_r[tgt_r] <= $signed(base_y_r + quo_y);
      end
      if (state_r == BK_STEP_END) begin
        if (phase_inc >= {1'b0, st_w_r}) begin
          phase_r <= '0;
          seg_r   <= nxt_w_r;
        end else begin
          phase_r <= phase_inc[TICK_W-1:0];
          seg_r   <= seg_w_r;
        end
        if (steps_r != 2'd2) begin
          steps_r <= steps_r + 1'b1;
        end
      end
      if (result_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (load_en) begin
      wpx_mem[addr_ld] <= pop_data.coord_x;
      wpy_mem[addr_ld] <= pop_data.coord_y;
    end
    if (mem_rd_en) begin
      rda_x_r <= wpx_mem[addr_a];
      rdb_x_r <= wpx_mem[addr_b];
      rda_y_r <= wpy_mem[addr_a];
      rdb_y_r <= wpy_mem[addr_b];
    end
    if (step_start) begin
      tgt_r      <= '0;
      tgt_last_r <= TGT_W'(tc_eff - 1'b1);
      ph_w_r     <= ph_norm;
      st_w_r     <= st_eff;
      wc_w_r     <= wc_eff;
      seg_w_r    <= seg_norm;
      nxt_w_r    <= nxt_norm;
    end
    if (state_r == BK_STEP_MUL) begin
      base_x_r  <= rda_x_r;
      base_y_r  <= rda_y_r;
      neg_x_r   <= diff_x[COORD_W];
      neg_y_r   <= diff_y[COORD_W];
      rem_x_r   <= prod_x[47:32];
      rem_y_r   <= prod_y[47:32];
      dvd_x_r   <= prod_x[31:0];
      dvd_y_r   <= prod_y[31:0];
      div_cnt_r <= '1;
    end
    if (state_r == BK_STEP_DIV) begin
      rem_x_r   <= qbit_x ? TICK_W'(trial_x - {1'b0, st_w_r}) : trial_x[TICK_W-1:0];
      rem_y_r   <= qbit_y ? TICK_W'(trial_y - {1'b0, st_w_r}) : trial_y[TICK_W-1:0];
      dvd_x_r   <= {dvd_x_r[COORD_W-2:0], qbit_x};
      dvd_y_r   <= {dvd_y_r[COORD_W-2:0], qbit_y};
      div_cnt_r <= div_cnt_r - 1'b1;
    end
    if (state_r == BK_STEP_WR) begin
      tgt_r <= tgt_r + 1'b1;
    end
    if (query_start) begin
      qtgt_r <= pop_data.target_index;
      qok_r  <= ({1'b0, pop_data.target_index} < (TGT_W+1)'(MAX_TARGETS));
    end
    if (state_r == BK_QRY_MUL) begin
      qpos_x_r  <= cur_x_r[qtgt_r];
      qpos_y_r  <= cur_y_r[qtgt_r];
      vprod_x_r <= vmul_x;
      vprod_y_r <= vmul_y;
    end
    if (result_load) begin
      pos_x_r <= qok_r ? qpos_x_r : '0;
      pos_y_r <= qok_r ? qpos_y_r : '0;
      vel_x_r <= vel_x_c;
      vel_y_r <= vel_y_c;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.pos_x = pos_x_r;
  assign out_ch.pos_y = pos_y_r;
  assign out_ch.vel_x = vel_x_r;
  assign out_ch.vel_y = vel_y_r;

  `WTI_ASSERT_NEXT(a_div_holds, clk, rst_n, (state_r == BK_STEP_DIV) && (div_cnt_r != '0), state_r == BK_STEP_DIV, "divider left early")
  `WTI_ASSERT_NOW(a_steps_sat, clk, rst_n, 1'b1, steps_r != 2'd3, "step count passed saturation")
  `WTI_ASSERT_NEXT(a_phase_wrap, clk, rst_n, state_r == BK_STEP_END, (phase_r < st_w_r) && ({1'b0, seg_r} < wc_w_r), "phase or segment out of range after step")
  `WTI_ASSERT_NOW(a_pop_idle, clk, rst_n, pop_valid && pop_ready, state_r == BK_IDLE, "command taken while busy")

endmodule

@@ design/waypoint_track_interpolator.sv @@
// Top level of the waypoint track interpolator: front, queue, back.
// Depends on wti_pkg, wti_if, wti_fifo, wti_front and wti_back.
//
//   channel  dir  carries
//   in_ch    in   opcode, target_index, waypoint_index, coord_x, coord_y
//   out_ch   out  pos_x, pos_y, vel_x, vel_y (one per query)
//   cfg_ch   in   reg_index, wdata (target/waypoint count, segment ticks, gain)
//
// A load is written while the back end idles; a query passes a multiply
// state and an output state, which waits while out_ch holds an untaken result.
// A step runs per target a waypoint read, a multiply, a restoring divide
// and a write, x and y side by side, then one closing state.
// Reset is synchronous; waypoint tables are not cleared and need no pass.
// The two-entry queue keeps in_ch open while the back end works; a waiting
// result holds in the output register and blocks only a later query.
module waypoint_track_interpolator (
  input logic        clk,
  input logic        rst_n,
  wti_in_if.sink     in_ch,
  wti_out_if.source  out_ch,
  wti_cfg_if.sink    cfg_ch
);
  import wti_pkg::*;

  // Front to queue
  logic push_valid, push_ready;
  cmd_t push_data;
  // Queue to back
  logic pop_valid, pop_ready;
  cmd_t pop_data;

  // Classify and drop no-effect commands.
  wti_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decouple intake from the slow step sequencer.
  wti_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Tables, positions and the shared multiply/divide.
  wti_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .cfg_ch    (cfg_ch),
    .out_ch    (out_ch)
  );

endmodule
